@@ design/lws_pkg.sv @@
// Shared types and constants for the latency window statistics block.
// No dependencies; imported by the top level and its port checker.
package lws_pkg;

   localparam int CNT_W      = 7;
   localparam int LAT_W      = 16;
   localparam int SAMPLE_W   = 17;
   localparam int SUM_W      = LAT_W + CNT_W;
   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int FRAC_SHIFT = 15;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LAT_W-1:0] FRACTION_ONE = 16'd32768;
   localparam logic [LAT_W-1:0] BAND_LIMIT_0 = 16'd160;
   localparam logic [LAT_W-1:0] BAND_LIMIT_1 = 16'd480;
   localparam logic [LAT_W-1:0] BAND_LIMIT_2 = 16'd1600;

   localparam logic [LAT_W-1:0] BUDGET_RESET = 16'd256;
   localparam logic [CNT_W-1:0] WSIZE_RESET  = 7'd64;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BUDGET_THRESHOLD = 1'b0,
      CSR_WINDOW_SIZE      = 1'b1
   } csr_addr_type;

   typedef enum logic {
      FUNC_RECORD = 1'b0,
      FUNC_CLEAR  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      BAND_UNDER_10MS  = 2'd0,
      BAND_UNDER_30MS  = 2'd1,
      BAND_UNDER_100MS = 2'd2,
      BAND_ABOVE       = 2'd3
   } band_type;

endpackage

@@ design/latency_window_statistics.sv @@
// Latency window statistics: after acceptance a request passes through update, a modulus
// division (overwrite only), a memory scan of the filled entries, the mean and fraction
// divisions (non-empty window only) and a finish state, which waits while a stalled result blocks.
// A new request is taken only in idle, after the previous result has been handed over; the
// shared 23-step restoring divider and the one-entry-per-cycle memory scan set the pace.
// Synchronous active-high reset clears control, counters and configuration only.
module latency_window_statistics
   import lws_pkg::*;
#(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [SAMPLE_W-1:0]   req_sample_latency,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LAT_W-1:0]      rsp_mean_latency,
   output logic [LAT_W-1:0]      rsp_worst_latency,
   output logic [LAT_W-1:0]      rsp_fraction_within,
   output logic [CNT_W-1:0]      rsp_sample_count,
   output logic [1:0]            rsp_band,
   output logic                  rsp_rejected,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_MOD,
      ST_SCAN,
      ST_DIV_MEAN,
      ST_DIV_FRAC,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic                 func_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [LAT_W-1:0]     budget_ff;
   logic [CNT_W-1:0]     wsize_ff;
   logic [CNT_W-1:0]     fill_ff;
   logic [CNT_W-1:0]     widx_ff;
   logic [CNT_W-1:0]     scan_cnt_ff;
   logic                 rd_vld_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [LAT_W-1:0]     worst_ff;
   logic [CNT_W-1:0]     within_ff;
   logic [LAT_W-1:0]     mean_ff;
   logic [1:0]           band_ff;
   logic                 rejected_ff;
   logic [SUM_W-1:0]     div_num_ff;
   logic [CNT_W-1:0]     div_rem_ff;
   logic [CNT_W-1:0]     div_den_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 rsp_valid_ff;
   logic [LAT_W-1:0]     rsp_mean_ff;
   logic [LAT_W-1:0]     rsp_worst_ff;
   logic [LAT_W-1:0]     rsp_frac_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic [1:0]           rsp_band_ff;
   logic                 rsp_rejected_ff;

   logic [LAT_W-1:0]     mem [WINDOW_DEPTH];
   logic [LAT_W-1:0]     mem_q_ff;

   logic [CNT_W-1:0]     cap;
   logic                 full;
   logic                 negative;
   logic [LAT_W-1:0]     sample_mag;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;
   logic [CNT_W:0]       div_shift;
   logic [CNT_W:0]       div_diff;
   logic                 div_ge;
   logic [CNT_W-1:0]     div_rem_in;
   logic [SUM_W-1:0]     div_num_in;
   logic                 div_last;
   logic                 out_free;
   band_type             band_in;

   always_comb begin
      if (wsize_ff == '0) begin
         cap = CNT_W'(1);
      end else if (32'(wsize_ff) > WINDOW_DEPTH) begin
         cap = CNT_W'(WINDOW_DEPTH);
      end else begin
         cap = wsize_ff;
      end
   end

   assign full       = (fill_ff >= cap);
   assign negative   = sample_ff[SAMPLE_W-1];
   assign sample_mag = sample_ff[LAT_W-1:0];

   always_comb begin
      if (sample_mag < BAND_LIMIT_0) begin
         band_in = BAND_UNDER_10MS;
      end else if (sample_mag < BAND_LIMIT_1) begin
         band_in = BAND_UNDER_30MS;
      end else if (sample_mag < BAND_LIMIT_2) begin
         band_in = BAND_UNDER_100MS;
      end else begin
         band_in = BAND_ABOVE;
      end
   end

   assign mem_we    = (state_ff == ST_UPDATE) && (func_ff == FUNC_RECORD) && !negative;
   assign mem_waddr = full ? AW'(widx_ff) : AW'(fill_ff);
   assign mem_raddr = AW'(scan_cnt_ff);

   assign div_shift  = {div_rem_ff, div_num_ff[SUM_W-1]};
   assign div_diff   = div_shift - {1'b0, div_den_ff};
   assign div_ge     = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
   assign div_num_in = {div_num_ff[SUM_W-2:0], div_ge};
   assign div_last   = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= sample_mag;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         wsize_ff  <= WSIZE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BUDGET_THRESHOLD: budget_ff <= csr_wdata[LAT_W-1:0];
            CSR_WINDOW_SIZE:      wsize_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         widx_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff   <= req_func;
                  sample_ff <= req_sample_latency;
                  state_ff  <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               scan_cnt_ff <= '0;
               rd_vld_ff   <= 1'b0;
               sum_ff      <= '0;
               worst_ff    <= '0;
               within_ff   <= '0;
               if (func_ff == FUNC_CLEAR) begin
                  band_ff     <= BAND_UNDER_10MS;
                  rejected_ff <= 1'b0;
                  fill_ff     <= '0;
                  widx_ff     <= '0;
                  state_ff    <= ST_SCAN;
               end else if (negative) begin
                  band_ff     <= BAND_UNDER_10MS;
                  rejected_ff <= 1'b1;
                  state_ff    <= ST_SCAN;
               end else begin
                  band_ff     <= band_in;
                  rejected_ff <= 1'b0;
                  if (!full) begin
                     fill_ff  <= fill_ff + CNT_W'(1);
                     state_ff <= ST_SCAN;
                  end else begin
                     div_num_ff <= SUM_W'(widx_ff) + SUM_W'(1);
                     div_den_ff <= cap;
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= ST_DIV_MOD;
                  end
               end
            end
            ST_DIV_MOD: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_last) begin
                  widx_ff  <= div_rem_in;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= (scan_cnt_ff < fill_ff);
               if (scan_cnt_ff < fill_ff) begin
                  scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               end
               if (rd_vld_ff) begin
                  sum_ff <= sum_ff + SUM_W'(mem_q_ff);
                  if (mem_q_ff > worst_ff) begin
                     worst_ff <= mem_q_ff;
                  end
                  if (mem_q_ff < budget_ff) begin
                     within_ff <= within_ff + CNT_W'(1);
                  end
               end
               if ((scan_cnt_ff == fill_ff) && !rd_vld_ff) begin
                  if (fill_ff == '0) begin
                     mean_ff    <= '0;
                     div_num_ff <= SUM_W'(FRACTION_ONE);
                     state_ff   <= ST_FINISH;
                  end else begin
                     div_num_ff <= sum_ff;
                     div_den_ff <= fill_ff;
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= ST_DIV_MEAN;
                  end
               end
            end
            ST_DIV_MEAN: begin
               if (div_last) begin
                  mean_ff    <= div_num_in[LAT_W-1:0];
                  div_num_ff <= SUM_W'({within_ff, {FRAC_SHIFT{1'b0}}});
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIV_FRAC;
               end else begin
                  div_num_ff <= div_num_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               end
            end
            ST_DIV_FRAC: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_mean_ff     <= mean_ff;
                  rsp_worst_ff    <= worst_ff;
                  rsp_frac_ff     <= div_num_ff[LAT_W-1:0];
                  rsp_count_ff    <= fill_ff;
                  rsp_band_ff     <= band_ff;
                  rsp_rejected_ff <= rejected_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_latency    = rsp_mean_ff;
   assign rsp_worst_latency   = rsp_worst_ff;
   assign rsp_fraction_within = rsp_frac_ff;
   assign rsp_sample_count    = rsp_count_ff;
   assign rsp_band            = rsp_band_ff;
   assign rsp_rejected        = rsp_rejected_ff;

endmodule

@@ design/lws_port_checker.sv @@
// Port-level checks for the latency window statistics block, bound to its top level.
// Depends on lws_pkg for field widths and the fraction scale.
module lws_port_checker
   import lws_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [LAT_W-1:0]   rsp_mean_latency,
   input logic [LAT_W-1:0]   rsp_worst_latency,
   input logic [LAT_W-1:0]   rsp_fraction_within,
   input logic [CNT_W-1:0]   rsp_sample_count,
   input logic [1:0]         rsp_band,
   input logic               rsp_rejected
);

   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_count == '0) |->
         (rsp_mean_latency == '0) && (rsp_worst_latency == '0) &&
         (rsp_fraction_within == FRACTION_ONE))
      else $error("empty window reports nonzero statistics");

   a_mean_below_worst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mean_latency <= rsp_worst_latency))
      else $error("mean exceeds worst latency");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fraction_within <= FRACTION_ONE))
      else $error("fraction above one");

   a_rejected_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> (rsp_band == BAND_UNDER_10MS))
      else $error("rejected request carries a band");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_latency) &&
         $stable(rsp_fraction_within))
      else $error("stalled response changed");

endmodule

bind latency_window_statistics lws_port_checker u_lws_port_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_mean_latency    (rsp_mean_latency),
   .rsp_worst_latency   (rsp_worst_latency),
   .rsp_fraction_within (rsp_fraction_within),
   .rsp_sample_count    (rsp_sample_count),
   .rsp_band            (rsp_band),
   .rsp_rejected        (rsp_rejected)
);
